@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HSIL_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Stalled channel: valid stays high and the payload holds on the next edge.
`define HSIL_ASSERT_HOLD(name, clk, rst_n, vld, rdy, dat, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(dat))) else $error(msg);

`endif

@@ sv/hsil_pkg.sv @@
`default_nettype none

package hsil_pkg;

	localparam int KEY_W       = 31;
	localparam int SIZE_W      = 5;
	localparam int SLOT_W      = 4;
	localparam int CMP_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd11;

	localparam logic [STATUS_W-1:0] STAT_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_PROBE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] rem;
	} mod_res_t;

endpackage

`default_nettype wire

@@ sv/hsil_mod_unit.sv @@
`default_nettype none

// Restoring remainder, one key bit per cycle, MSB first.
module hsil_mod_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hsil_pkg::KEY_W-1:0]    dividend,
	input  wire logic [hsil_pkg::SIZE_W-1:0]   divisor,
	output hsil_pkg::mod_res_t                 res
);

	localparam int CNT_W = $clog2(hsil_pkg::KEY_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hsil_pkg::KEY_W - 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [hsil_pkg::KEY_W-1:0]    sh_q;
	logic [hsil_pkg::SIZE_W-1:0]   div_q;
	logic [hsil_pkg::SIZE_W-1:0]   rem_q;
	logic [hsil_pkg::SIZE_W:0]     trial;
	logic                          ge;
	logic [hsil_pkg::SIZE_W-1:0]   rem_next;

	always_comb begin
		trial    = {rem_q, sh_q[hsil_pkg::KEY_W-1]};
		ge       = trial >= {1'b0, div_q};
		// rem < divisor, so trial < 2*divisor and one subtract is enough
		rem_next = ge ? hsil_pkg::SIZE_W'(trial - {1'b0, div_q})
		              : trial[hsil_pkg::SIZE_W-1:0];
		res.done = busy_q && (cnt_q == CNT_LAST);
		res.rem  = rem_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[hsil_pkg::KEY_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/hsil_slot_mem.sv @@
`default_nettype none

// Slot store: one read port with registered data, one write port.
// After reset every entry is swept to zero, one per cycle.
module hsil_slot_mem #(
	parameter  int DEPTH = hsil_pkg::DEPTH_DEFAULT,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [hsil_pkg::KEY_W-1:0]  rd_data,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [hsil_pkg::KEY_W-1:0]  wr_data,
	output logic                             clear_busy
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [hsil_pkg::KEY_W-1:0] mem [DEPTH];
	logic [AW-1:0]              clr_q;
	logic                       busy_q;

	assign clear_busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

@@ sv/hash_search_insert_linear_probe.sv @@
// Flow: an accepted key goes through the bit-serial remainder to find its home slot, then
//   probes one slot per cycle through the slot store's single read port until a hit, an empty
//   slot or a wrap back to home, so at most table size slots; a zero key skips both steps.
//   One item at a time: input is taken again only after the result is loaded for output.
// Reset: asynchronous, active low; the slot store is then swept to empty, with s_axis_tready
//   low until the sweep is done. table_size resets to 11.
`default_nettype none

module hash_search_insert_linear_probe #(
	parameter int TABLE_DEPTH = hsil_pkg::DEPTH_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [hsil_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [30:0] key
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic      [hsil_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [1:0] status,
	                                                                 // [5:2] slot_index,
	                                                                 // [10:6] compares
	input  wire logic                                 cfg_wr_en,
	input  wire logic [hsil_pkg::SIZE_W-1:0]          cfg_wr_data    // table_size
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int PW    = (IDX_W > hsil_pkg::SIZE_W) ? IDX_W : hsil_pkg::SIZE_W;
	localparam int RES_W = hsil_pkg::STATUS_W + hsil_pkg::SLOT_W + hsil_pkg::CMP_W;

	hsil_pkg::state_t state_q, state_d;

	logic [hsil_pkg::SIZE_W-1:0]   table_size_q;
	logic [hsil_pkg::SIZE_W-1:0]   eff_size;
	logic [hsil_pkg::KEY_W-1:0]    in_key;
	logic                          accept;
	logic                          mod_start;
	hsil_pkg::mod_res_t            mod_res;

	logic [hsil_pkg::KEY_W-1:0]    key_q;
	logic [hsil_pkg::SIZE_W-1:0]   size_q;
	logic [PW-1:0]                 idx_q;
	logic [PW-1:0]                 home_q;
	logic [hsil_pkg::CMP_W-1:0]    cmp_q;
	logic [hsil_pkg::STATUS_W-1:0] res_status_q;
	logic [hsil_pkg::SLOT_W-1:0]   res_slot_q;
	logic [hsil_pkg::CMP_W-1:0]    res_cmp_q;
	logic                          out_valid_q;
	logic [hsil_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [PW-1:0]                 rem_ext;
	logic [PW-1:0]                 idx_inc;
	logic [PW-1:0]                 next_idx;
	logic                          at_home;
	logic [hsil_pkg::CMP_W-1:0]    cmp_inc;
	logic                          hit;
	logic                          empty;
	logic                          wraps;
	logic                          probe_end;
	logic [hsil_pkg::STATUS_W-1:0] pr_status;
	logic [PW-1:0]                 pr_slot;
	logic [hsil_pkg::CMP_W-1:0]    pr_cmp;

	logic [PW-1:0]                 rd_addr;
	logic [hsil_pkg::KEY_W-1:0]    rd_data;
	logic                          wr_en;
	logic                          clear_busy;
	logic                          emit_load;

	assign in_key = s_axis_tdata[hsil_pkg::KEY_W-1:0];
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (table_size_q == '0)
			eff_size = hsil_pkg::SIZE_W'(1);
		else if (int'(table_size_q) > TABLE_DEPTH)
			eff_size = hsil_pkg::SIZE_W'(TABLE_DEPTH);
		else
			eff_size = table_size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_size_q <= hsil_pkg::SIZE_RESET;
		else if (cfg_wr_en)
			table_size_q <= cfg_wr_data;
	end

	hsil_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (in_key),
		.divisor  (eff_size),
		.res      (mod_res)
	);

	hsil_slot_mem #(
		.DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr[IDX_W-1:0]),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (idx_q[IDX_W-1:0]),
		.wr_data    (key_q),
		.clear_busy (clear_busy)
	);

	// Probe step: rd_data holds the slot at idx_q, the next slot is read meanwhile.
	always_comb begin
		rem_ext   = PW'(mod_res.rem);
		idx_inc   = idx_q + PW'(1);
		next_idx  = (idx_inc == PW'(size_q)) ? '0 : idx_inc;
		at_home   = idx_q == home_q;
		cmp_inc   = at_home ? cmp_q : cmp_q + hsil_pkg::CMP_W'(1);
		hit       = rd_data == key_q;
		empty     = rd_data == '0;
		wraps     = next_idx == home_q;
		probe_end = hit || empty || wraps;
		if (empty) begin
			pr_status = hsil_pkg::STAT_INSERTED;
			pr_slot   = idx_q;
			pr_cmp    = cmp_q;
		end else if (hit) begin
			pr_status = hsil_pkg::STAT_FOUND;
			pr_slot   = idx_q;
			pr_cmp    = cmp_inc;
		end else begin
			pr_status = hsil_pkg::STAT_FULL;
			pr_slot   = home_q;
			pr_cmp    = cmp_inc;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hsil_pkg::ST_CLEAR: begin
				if (!clear_busy)
					state_d = hsil_pkg::ST_IDLE;
			end
			hsil_pkg::ST_IDLE: begin
				if (accept)
					state_d = (in_key == '0) ? hsil_pkg::ST_EMIT : hsil_pkg::ST_DIV;
			end
			hsil_pkg::ST_DIV: begin
				if (mod_res.done)
					state_d = hsil_pkg::ST_PROBE;
			end
			hsil_pkg::ST_PROBE: begin
				if (probe_end)
					state_d = hsil_pkg::ST_EMIT;
			end
			hsil_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready)
					state_d = hsil_pkg::ST_IDLE;
			end
			default: state_d = hsil_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mod_start     = 1'b0;
		rd_addr       = next_idx;
		wr_en         = 1'b0;
		emit_load     = 1'b0;
		case (state_q)
			hsil_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				mod_start     = s_axis_tvalid && (in_key != '0);
			end
			hsil_pkg::ST_DIV: begin
				rd_addr = rem_ext;
			end
			hsil_pkg::ST_PROBE: begin
				wr_en = empty;
			end
			hsil_pkg::ST_EMIT: begin
				emit_load = !out_valid_q || m_axis_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hsil_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q        <= in_key;
			size_q       <= eff_size;
			// zero key: rejected, these stand as the result
			res_status_q <= hsil_pkg::STAT_FULL;
			res_slot_q   <= '0;
			res_cmp_q    <= hsil_pkg::CMP_W'(1);
		end
		if (state_q == hsil_pkg::ST_DIV && mod_res.done) begin
			idx_q  <= rem_ext;
			home_q <= rem_ext;
			cmp_q  <= hsil_pkg::CMP_W'(1);
		end
		if (state_q == hsil_pkg::ST_PROBE) begin
			idx_q <= next_idx;
			cmp_q <= cmp_inc;
			if (probe_end) begin
				res_status_q <= pr_status;
				res_slot_q   <= pr_slot[hsil_pkg::SLOT_W-1:0];
				res_cmp_q    <= pr_cmp;
			end
		end
	end

	// Output register: holds a result while the next item is taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load)
			out_data_q <= {(hsil_pkg::OUT_TDATA_W - RES_W)'(0), res_cmp_q, res_slot_q,
			               res_status_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ sv/hsil_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module hsil_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	`HSIL_ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result changed while stalled")

	// one item at a time: input closes right after an item is taken
	`HSIL_ASSERT(a_one_in_flight, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input still ready after accept")

	`HSIL_ASSERT(a_status_code, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3), "undefined status code")

	`HSIL_ASSERT(a_cmp_nonzero, clk, arst_n, m_axis_tvalid |-> ((m_axis_tdata[10:6] != 5'd0) && (m_axis_tdata[15:11] == 5'd0)), "bad compare count or padding")

endmodule

bind hash_search_insert_linear_probe hsil_checker u_hsil_checker (.*);

`default_nettype wire
